// File: hw/rtl/smva_pkg.sv
package smva_pkg;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int FRAC_W  = 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        ACT_LOAD_VEC = 2'd0,
        ACT_LOAD_RES = 2'd1,
        ACT_APPLY    = 2'd2,
        ACT_READ     = 2'd3
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [VAL_W-1:0]   value;
        logic                      last_entry;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0]   read_value;
        logic                      saturated;
        logic                      done_res;
    } t_out_item;

    // Classified operation as it travels from the front end to the back end.
    typedef struct packed {
        t_action                   action;
        logic                      row_ok;
        logic                      col_ok;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VAL_W-1:0]   value;
        logic                      last;
    } t_op;

endpackage

// File: hw/rtl/smva_front.sv
module smva_front #(
    parameter int VEC_DEPTH = 1024,
    parameter int ROW_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  smva_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    input  logic              i_clearing,
    output logic              o_push,
    output smva_pkg::t_op     o_op
);
    import smva_pkg::*;

    localparam int CMP_W = 18;

    logic r_ready;

    // No beat is taken while the result memory is being cleared after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= !i_clearing;
        end
    end

    assign o_in_stall = i_q_full || !r_ready || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall;

    always_comb begin
        o_op.action = i_in_item.action;
        o_op.row    = i_in_item.row_index;
        o_op.col    = i_in_item.col_index;
        o_op.value  = i_in_item.value;
        o_op.last   = i_in_item.last_entry && (i_in_item.action == ACT_APPLY);
        o_op.row_ok = CMP_W'(i_in_item.row_index) < CMP_W'(ROW_DEPTH);
        o_op.col_ok = CMP_W'(i_in_item.col_index) < CMP_W'(VEC_DEPTH);
    end

endmodule

// File: hw/rtl/smva_queue.sv
module smva_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smva_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output smva_pkg::t_op o_op
);
    import smva_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/smva_back.sv
module smva_back #(
    parameter int VEC_DEPTH = 1024,
    parameter int ROW_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sub_mode,
    input  logic                i_q_valid,
    input  smva_pkg::t_op       i_q_op,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output smva_pkg::t_out_item o_out_item
);
    import smva_pkg::*;

    localparam int VA_W  = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam int RA_W  = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int VX_W  = (VA_W > IDX_W) ? VA_W : IDX_W;
    localparam int RX_W  = (RA_W > IDX_W) ? RA_W : IDX_W;
    localparam logic [RA_W-1:0] LAST_ROW = RA_W'(ROW_DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_ACC   = 4'b1000
    } t_state;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [VAL_W-1:0] r_vec_mem [VEC_DEPTH];
    logic signed [ACC_W-1:0] r_res_mem [ROW_DEPTH];

    t_state                   r_state;
    t_state                   n_state;
    logic [RA_W-1:0]          r_clr_cnt;
    t_op                      r_op;
    logic signed [VAL_W-1:0]  r_vec_q;
    logic signed [ACC_W-1:0]  r_res_q;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     res_we;
    logic [RA_W-1:0]          res_waddr;
    logic signed [ACC_W-1:0]  res_wdata;
    logic                     vec_we;
    logic [VX_W-1:0]          col_x;
    logic [RX_W-1:0]          row_x;
    logic [VX_W-1:0]          head_col_x;
    logic [RX_W-1:0]          head_row_x;
    logic signed [ACC_W-1:0]  prod_q;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  sum_sat;
    logic                     sum_ovf;
    logic                     produce;
    t_out_item                n_out;

    assign col_x      = VX_W'(r_op.col);
    assign row_x      = RX_W'(r_op.row);
    assign head_col_x = VX_W'(i_q_op.col);
    assign head_row_x = RX_W'(i_q_op.row);

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_pop       = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The product is Q32.32 and at most 2^62 in magnitude, so dropping the low
    // sixteen bits is the floor shift and the rest fits in Q32.16.
    assign prod_q = r_prod[PROD_W-1 -: ACC_W];

    always_comb begin
        if (i_sub_mode) begin
            sum = {r_res_q[ACC_W-1], r_res_q} - {prod_q[ACC_W-1], prod_q};
        end else begin
            sum = {r_res_q[ACC_W-1], r_res_q} + {prod_q[ACC_W-1], prod_q};
        end
        sum_ovf = sum[ACC_W] != sum[ACC_W-1];
        if (!sum_ovf) begin
            sum_sat = sum[ACC_W-1:0];
        end else if (sum[ACC_W]) begin
            sum_sat = ACC_MIN;
        end else begin
            sum_sat = ACC_MAX;
        end
    end

    always_comb begin
        n_state   = r_state;
        res_we    = 1'b0;
        res_waddr = row_x[RA_W-1:0];
        res_wdata = sum_sat;
        vec_we    = 1'b0;
        produce   = 1'b0;
        n_out     = '0;
        case (r_state)
            S_CLEAR: begin
                res_we    = 1'b1;
                res_waddr = r_clr_cnt;
                res_wdata = '0;
                if (r_clr_cnt == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op.action)
                    ACT_LOAD_VEC: begin
                        vec_we  = r_op.col_ok;
                        produce = 1'b1;
                        n_state = S_IDLE;
                    end
                    ACT_LOAD_RES: begin
                        res_we    = r_op.row_ok;
                        res_wdata = ACC_W'(r_op.value);
                        produce   = 1'b1;
                        n_state   = S_IDLE;
                    end
                    ACT_READ: begin
                        n_out.read_value = r_op.row_ok ? r_res_q : '0;
                        produce          = 1'b1;
                        n_state          = S_IDLE;
                    end
                    default: begin
                        if (r_op.row_ok && r_op.col_ok) begin
                            n_state = S_ACC;
                        end else begin
                            n_out.done_res = r_op.last;
                            produce        = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                endcase
            end
            S_ACC: begin
                res_we          = 1'b1;
                n_out.saturated = sum_ovf;
                n_out.done_res  = r_op.last;
                produce         = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) begin
            r_vec_mem[col_x[VA_W-1:0]] <= r_op.value;
        end
        if (o_pop) begin
            r_vec_q <= r_vec_mem[head_col_x[VA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_res_mem[res_waddr] <= res_wdata;
        end
        if (o_pop) begin
            r_res_q <= r_res_mem[head_row_x[RA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_q_op;
        end
        if (r_state == S_EXEC) begin
            r_prod <= r_op.value * r_vec_q;
        end
        if (produce) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/sparse_matrix_vector_accumulate.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_item  (smva_pkg::t_in_item)
// out       output     o_out_valid / i_out_stall o_out_item (smva_pkg::t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (subtract mode)
//
// Every beat gives exactly one result beat. A load or read in the back end
// is a registered memory read, then the write or result; a nonzero is a
// registered memory read, then the 32x32 multiply, then the 48-bit add or
// subtract with saturation and write. After reset the result memory is swept
// to zero, one row a cycle, rows 0 to ROW_DEPTH-1; input beats stall meanwhile.
// A four-entry queue between front and back absorbs stalls on either side.
module sparse_matrix_vector_accumulate #(
    parameter int VEC_DEPTH = 1024,
    parameter int ROW_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  smva_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output smva_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import smva_pkg::*;

    logic r_sub_mode;
    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    logic clearing;
    t_op  front_op;
    t_op  head_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sub_mode <= i_cfg_data;
        end
    end

    smva_front #(
        .VEC_DEPTH (VEC_DEPTH),
        .ROW_DEPTH (ROW_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_push     (push),
        .o_op       (front_op)
    );

    smva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    smva_back #(
        .VEC_DEPTH (VEC_DEPTH),
        .ROW_DEPTH (ROW_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sub_mode  (r_sub_mode),
        .i_q_valid   (q_valid),
        .i_q_op      (head_op),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
